// ----- hw/rtl/irc_line_tokenizer_top_defines.svh -----
// Assertion macros for the IRC line tokenizer.
`ifndef IRC_LINE_TOKENIZER_TOP_DEFINES_SVH
`define IRC_LINE_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IRC_LT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irc_line_tokenizer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IRC_LT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irc_line_tokenizer: next-cycle check failed");

`endif

// ----- hw/rtl/irc_lt_pkg.sv -----
`timescale 1ns / 1ps

package irc_lt_pkg;

    localparam logic [3:0] MAX_PARAMS = 4'd15;
    localparam logic [9:0] LIMIT_RESET = 10'd512;
    localparam logic [9:0] COUNT_MAX = 10'h3FF;

    // parser phases
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_WAIT   = 3'd1;
    localparam logic [2:0] PH_PREFIX = 3'd2;
    localparam logic [2:0] PH_CMD    = 3'd3;
    localparam logic [2:0] PH_PSTART = 3'd4;
    localparam logic [2:0] PH_MID    = 3'd5;
    localparam logic [2:0] PH_TRAIL  = 3'd6;
    localparam logic [2:0] PH_TAIL   = 3'd7;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // token kinds
    localparam logic [2:0] KIND_SEP    = 3'd0;
    localparam logic [2:0] KIND_PREFIX = 3'd1;
    localparam logic [2:0] KIND_CMD    = 3'd2;
    localparam logic [2:0] KIND_MIDDLE = 3'd3;
    localparam logic [2:0] KIND_TRAIL  = 3'd4;
    localparam logic [2:0] KIND_RAW    = 3'd5;

    // line status
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_PING        = 3'd1;
    localparam logic [2:0] ST_NO_PREFIX   = 3'd2;
    localparam logic [2:0] ST_PREFIX_LONG = 3'd3;
    localparam logic [2:0] ST_NO_CMD_END  = 3'd4;
    localparam logic [2:0] ST_NO_LINE_END = 3'd5;
    localparam logic [2:0] ST_TOO_MANY    = 3'd6;

    // ping matcher: 0 idle, 1..4 matching, 5 matched, 6 mismatch
    localparam logic [2:0] PING_IDLE  = 3'd0;
    localparam logic [2:0] PING_FIRST = 3'd1;
    localparam logic [2:0] PING_LAST  = 3'd4;
    localparam logic [2:0] PING_HIT   = 3'd5;
    localparam logic [2:0] PING_MISS  = 3'd6;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [2:0] token_kind;
        logic [3:0] param_index;
        logic       token_end;
        logic       line_done;
        logic [2:0] status;
        logic [3:0] param_total;
    } result_t;

    function automatic logic [7:0] ping_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h50;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h4E;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/irc_lt_core.sv -----
`timescale 1ns / 1ps

module irc_lt_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [7:0]          byte_in,
    input  logic [9:0]          line_limit,
    output irc_lt_pkg::result_t result
);

    logic [2:0] phase_reg, phase_next;
    logic [9:0] bc_reg, bc_next;
    logic [3:0] pcnt_reg, pcnt_next;
    logic [2:0] ping_reg, ping_next;
    logic [2:0] status_reg, status_next;

    logic [2:0] kind;
    logic [3:0] pidx;
    logic       tend;
    logic       done;
    logic [2:0] st;
    logic [3:0] cnt_o;

    always_comb
    begin
        phase_next  = phase_reg;
        bc_next     = bc_reg;
        pcnt_next   = pcnt_reg;
        ping_next   = ping_reg;
        status_next = status_reg;
        kind  = irc_lt_pkg::KIND_SEP;
        pidx  = 4'd0;
        tend  = 1'b0;
        done  = 1'b0;
        st    = irc_lt_pkg::ST_OK;
        cnt_o = 4'd0;

        // length overflow on a tokenized line
        if (phase_next >= irc_lt_pkg::PH_PREFIX && bc_next >= line_limit)
        begin
            priority if (phase_next == irc_lt_pkg::PH_PREFIX)
                status_next = irc_lt_pkg::ST_PREFIX_LONG;
            else if (phase_next == irc_lt_pkg::PH_CMD)
                status_next = irc_lt_pkg::ST_NO_CMD_END;
            else
                status_next = irc_lt_pkg::ST_NO_LINE_END;
            phase_next = irc_lt_pkg::PH_WAIT;
            ping_next  = irc_lt_pkg::PING_IDLE;
        end

        if (phase_next == irc_lt_pkg::PH_PSTART && pcnt_next >= irc_lt_pkg::MAX_PARAMS &&
            status_next == irc_lt_pkg::ST_OK)
            status_next = irc_lt_pkg::ST_TOO_MANY;

        if (phase_next >= irc_lt_pkg::PH_PSTART && phase_next <= irc_lt_pkg::PH_TRAIL)
            pidx = pcnt_next;

        if (byte_in == irc_lt_pkg::CH_LF)
        begin
            done = 1'b1;
            unique case (phase_next)
                irc_lt_pkg::PH_START:
                    st = irc_lt_pkg::ST_NO_PREFIX;
                irc_lt_pkg::PH_PREFIX:
                begin
                    st   = irc_lt_pkg::ST_PREFIX_LONG;
                    tend = 1'b1;
                end
                irc_lt_pkg::PH_CMD:
                begin
                    st   = irc_lt_pkg::ST_NO_CMD_END;
                    tend = 1'b1;
                end
                irc_lt_pkg::PH_PSTART, irc_lt_pkg::PH_MID, irc_lt_pkg::PH_TRAIL:
                begin
                    tend = 1'b1;
                    if (pcnt_next < irc_lt_pkg::MAX_PARAMS)
                        pcnt_next = pcnt_next + 4'd1;
                    st = status_next;
                end
                default:
                    st = status_next;
            endcase
            cnt_o       = pcnt_next;
            phase_next  = irc_lt_pkg::PH_START;
            bc_next     = 10'd0;
            pcnt_next   = 4'd0;
            ping_next   = irc_lt_pkg::PING_IDLE;
            status_next = irc_lt_pkg::ST_OK;
        end
        else
        begin
            unique case (phase_next)
                irc_lt_pkg::PH_START:
                begin
                    if (byte_in == irc_lt_pkg::CH_COLON)
                    begin
                        kind       = irc_lt_pkg::KIND_PREFIX;
                        phase_next = irc_lt_pkg::PH_PREFIX;
                    end
                    else
                    begin
                        kind        = irc_lt_pkg::KIND_RAW;
                        phase_next  = irc_lt_pkg::PH_WAIT;
                        status_next = irc_lt_pkg::ST_NO_PREFIX;
                        ping_next   = (byte_in == irc_lt_pkg::ping_char(3'd0)) ?
                                      irc_lt_pkg::PING_FIRST : irc_lt_pkg::PING_MISS;
                    end
                end
                irc_lt_pkg::PH_WAIT:
                begin
                    kind = irc_lt_pkg::KIND_RAW;
                    if (ping_next >= irc_lt_pkg::PING_FIRST && ping_next <= irc_lt_pkg::PING_LAST)
                    begin
                        if (byte_in == irc_lt_pkg::ping_char(ping_next))
                        begin
                            if (ping_next == irc_lt_pkg::PING_LAST)
                                status_next = irc_lt_pkg::ST_PING;
                            ping_next = ping_next + 3'd1;
                        end
                        else
                            ping_next = irc_lt_pkg::PING_MISS;
                    end
                end
                irc_lt_pkg::PH_PREFIX:
                begin
                    if (byte_in == irc_lt_pkg::CH_SP)
                    begin
                        tend       = 1'b1;
                        phase_next = irc_lt_pkg::PH_CMD;
                    end
                    else
                        kind = irc_lt_pkg::KIND_PREFIX;
                end
                irc_lt_pkg::PH_CMD:
                begin
                    if (byte_in == irc_lt_pkg::CH_SP)
                    begin
                        tend       = 1'b1;
                        phase_next = irc_lt_pkg::PH_PSTART;
                    end
                    else
                        kind = irc_lt_pkg::KIND_CMD;
                end
                irc_lt_pkg::PH_PSTART, irc_lt_pkg::PH_MID:
                begin
                    if (byte_in == irc_lt_pkg::CH_SP || byte_in == irc_lt_pkg::CH_CR)
                    begin
                        tend = 1'b1;
                        if (pcnt_next < irc_lt_pkg::MAX_PARAMS)
                            pcnt_next = pcnt_next + 4'd1;
                        if (byte_in == irc_lt_pkg::CH_CR)
                            phase_next = irc_lt_pkg::PH_TAIL;
                        else
                            phase_next = irc_lt_pkg::PH_PSTART;
                    end
                    else if (phase_next == irc_lt_pkg::PH_PSTART &&
                             byte_in == irc_lt_pkg::CH_COLON)
                    begin
                        kind       = irc_lt_pkg::KIND_TRAIL;
                        phase_next = irc_lt_pkg::PH_TRAIL;
                    end
                    else
                    begin
                        kind       = irc_lt_pkg::KIND_MIDDLE;
                        phase_next = irc_lt_pkg::PH_MID;
                    end
                end
                irc_lt_pkg::PH_TRAIL:
                begin
                    if (byte_in == irc_lt_pkg::CH_CR)
                    begin
                        tend = 1'b1;
                        if (pcnt_next < irc_lt_pkg::MAX_PARAMS)
                            pcnt_next = pcnt_next + 4'd1;
                        phase_next = irc_lt_pkg::PH_TAIL;
                    end
                    else
                        kind = irc_lt_pkg::KIND_TRAIL;
                end
                default:
                    kind = irc_lt_pkg::KIND_SEP;
            endcase
            if (bc_next != irc_lt_pkg::COUNT_MAX)
                bc_next = bc_next + 10'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= irc_lt_pkg::PH_START;
            bc_reg     <= 10'd0;
            pcnt_reg   <= 4'd0;
            ping_reg   <= irc_lt_pkg::PING_IDLE;
            status_reg <= irc_lt_pkg::ST_OK;
        end
        else if (en)
        begin
            phase_reg  <= phase_next;
            bc_reg     <= bc_next;
            pcnt_reg   <= pcnt_next;
            ping_reg   <= ping_next;
            status_reg <= status_next;
        end
    end

    assign result.byte_out    = byte_in;
    assign result.token_kind  = kind;
    assign result.param_index = pidx;
    assign result.token_end   = tend;
    assign result.line_done   = done;
    assign result.status      = st;
    assign result.param_total = cnt_o;

endmodule

// ----- hw/rtl/irc_line_tokenizer_top.sv -----
// IRC line tokenizer: one byte of an IRC line per item on the rx channel,
// one tagged byte per item on the tx channel (token kind, parameter index,
// token end, and at LF the line status and parameter count).
// Both channels: item moves on a clock edge with valid high and stall low.
// A byte accepted into the input register passes the parser into the result register, then shows on tx.
// Throughput: one item per cycle while tx is not stalled; the per-byte parser
// state update is combinational between the input and result registers.
// A held tx item does not block rx while the input register is free; with
// both registers full, rx_stall follows tx_stall.
// cfg_wr_en/cfg_wr_data write line_limit (reset 512); write only when idle.
// Reset (rst_n low, async) empties both registers and returns the parser to
// start of line with all counters and the status cleared.
// LF always ends a line and returns the parser to start of line.
`timescale 1ns / 1ps
`include "irc_line_tokenizer_top_defines.svh"

module irc_line_tokenizer_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [9:0] cfg_wr_data,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] byte_in,
    output logic       tx_valid,
    input  logic       tx_stall,
    output logic [7:0] byte_out,
    output logic [2:0] token_kind,
    output logic [3:0] param_index,
    output logic       token_end,
    output logic       line_done,
    output logic [2:0] status,
    output logic [3:0] param_total
);

    logic [9:0]          limit_reg;
    logic                s1_valid_reg;
    logic [7:0]          s1_byte_reg;
    logic                tx_valid_reg;
    irc_lt_pkg::result_t res_reg;
    irc_lt_pkg::result_t core_res;
    logic                advance;
    logic                s1_free;
    logic                step_en;

    assign advance  = !tx_valid_reg || !tx_stall;
    assign s1_free  = !s1_valid_reg || advance;
    assign rx_stall = !s1_free;
    assign step_en  = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= irc_lt_pkg::LIMIT_RESET;
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= rx_valid;
            if (advance)
                tx_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && rx_valid)
            s1_byte_reg <= byte_in;
        if (step_en)
            res_reg <= core_res;
    end

    irc_lt_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (step_en),
        .byte_in    (s1_byte_reg),
        .line_limit (limit_reg),
        .result     (core_res)
    );

    assign tx_valid    = tx_valid_reg;
    assign byte_out    = res_reg.byte_out;
    assign token_kind  = res_reg.token_kind;
    assign param_index = res_reg.param_index;
    assign token_end   = res_reg.token_end;
    assign line_done   = res_reg.line_done;
    assign status      = res_reg.status;
    assign param_total = res_reg.param_total;

    `IRC_LT_ASSERT_NOW(a_done_is_sep, clk, rst_n,
        tx_valid_reg && (res_reg.line_done || res_reg.token_end),
        res_reg.token_kind == irc_lt_pkg::KIND_SEP)
    `IRC_LT_ASSERT_NOW(a_status_only_at_done, clk, rst_n,
        tx_valid_reg && !res_reg.line_done,
        res_reg.status == irc_lt_pkg::ST_OK && res_reg.param_total == 4'd0)
    `IRC_LT_ASSERT_NEXT(a_s1_held_on_stall, clk, rst_n,
        s1_valid_reg && tx_valid_reg && tx_stall,
        s1_valid_reg && $stable(s1_byte_reg))

endmodule

// ----- verif/irc_line_tokenizer_top_tb.sv -----
`timescale 1ns / 1ps

class irc_tag_tracker;
    logic [9:0] limit_reg;
    logic [2:0] ph;
    logic [9:0] nbytes;
    logic [3:0] nparams;
    logic [2:0] ping_pos;
    logic [2:0] line_st;
    logic [39:0] ping_word;
    irc_lt_pkg::result_t tag_q[$];
    int errors;

    function new();
        limit_reg = irc_lt_pkg::LIMIT_RESET;
        ping_word = "PING ";
        errors = 0;
        clear_line();
    endfunction

    function void clear_line();
        ph = irc_lt_pkg::PH_START;
        nbytes = '0;
        nparams = '0;
        ping_pos = irc_lt_pkg::PING_IDLE;
        line_st = irc_lt_pkg::ST_OK;
    endfunction

    function void bump_params();
        if (nparams < irc_lt_pkg::MAX_PARAMS)
            nparams++;
    endfunction

    function int pending();
        return tag_q.size();
    endfunction

    // tag one accepted byte and queue the tagged item
    function void accept_byte(logic [7:0] b);
        irc_lt_pkg::result_t r;
        r = '0;
        r.byte_out = b;
        r.token_kind = irc_lt_pkg::KIND_SEP;
        if (ph >= irc_lt_pkg::PH_PREFIX && nbytes >= limit_reg)
        begin
            if (ph == irc_lt_pkg::PH_PREFIX)
                line_st = irc_lt_pkg::ST_PREFIX_LONG;
            else if (ph == irc_lt_pkg::PH_CMD)
                line_st = irc_lt_pkg::ST_NO_CMD_END;
            else
                line_st = irc_lt_pkg::ST_NO_LINE_END;
            ph = irc_lt_pkg::PH_WAIT;
            ping_pos = irc_lt_pkg::PING_IDLE;
        end
        if (ph == irc_lt_pkg::PH_PSTART && nparams >= irc_lt_pkg::MAX_PARAMS &&
            line_st == irc_lt_pkg::ST_OK)
            line_st = irc_lt_pkg::ST_TOO_MANY;
        if (ph >= irc_lt_pkg::PH_PSTART && ph <= irc_lt_pkg::PH_TRAIL)
            r.param_index = nparams;
        if (b == irc_lt_pkg::CH_LF)
        begin
            r.line_done = 1'b1;
            unique case (ph)
                irc_lt_pkg::PH_START:
                    r.status = irc_lt_pkg::ST_NO_PREFIX;
                irc_lt_pkg::PH_PREFIX:
                begin
                    r.status = irc_lt_pkg::ST_PREFIX_LONG;
                    r.token_end = 1'b1;
                end
                irc_lt_pkg::PH_CMD:
                begin
                    r.status = irc_lt_pkg::ST_NO_CMD_END;
                    r.token_end = 1'b1;
                end
                irc_lt_pkg::PH_PSTART, irc_lt_pkg::PH_MID, irc_lt_pkg::PH_TRAIL:
                begin
                    r.token_end = 1'b1;
                    bump_params();
                    r.status = line_st;
                end
                default:
                    r.status = line_st;
            endcase
            r.param_total = nparams;
            clear_line();
        end
        else
        begin
            unique case (ph)
                irc_lt_pkg::PH_START:
                begin
                    if (b == irc_lt_pkg::CH_COLON)
                    begin
                        r.token_kind = irc_lt_pkg::KIND_PREFIX;
                        ph = irc_lt_pkg::PH_PREFIX;
                    end
                    else
                    begin
                        r.token_kind = irc_lt_pkg::KIND_RAW;
                        ph = irc_lt_pkg::PH_WAIT;
                        line_st = irc_lt_pkg::ST_NO_PREFIX;
                        ping_pos = (b == ping_word[39:32]) ?
                                   irc_lt_pkg::PING_FIRST : irc_lt_pkg::PING_MISS;
                    end
                end
                irc_lt_pkg::PH_WAIT:
                begin
                    r.token_kind = irc_lt_pkg::KIND_RAW;
                    if (ping_pos >= irc_lt_pkg::PING_FIRST && ping_pos <= irc_lt_pkg::PING_LAST)
                    begin
                        if (b == ping_word[8 * (4 - ping_pos) +: 8])
                        begin
                            ping_pos++;
                            if (ping_pos == irc_lt_pkg::PING_HIT)
                                line_st = irc_lt_pkg::ST_PING;
                        end
                        else
                            ping_pos = irc_lt_pkg::PING_MISS;
                    end
                end
                irc_lt_pkg::PH_PREFIX:
                begin
                    if (b == irc_lt_pkg::CH_SP)
                    begin
                        r.token_end = 1'b1;
                        ph = irc_lt_pkg::PH_CMD;
                    end
                    else
                        r.token_kind = irc_lt_pkg::KIND_PREFIX;
                end
                irc_lt_pkg::PH_CMD:
                begin
                    if (b == irc_lt_pkg::CH_SP)
                    begin
                        r.token_end = 1'b1;
                        ph = irc_lt_pkg::PH_PSTART;
                    end
                    else
                        r.token_kind = irc_lt_pkg::KIND_CMD;
                end
                irc_lt_pkg::PH_PSTART:
                begin
                    if (b == irc_lt_pkg::CH_SP)
                    begin
                        r.token_end = 1'b1;
                        bump_params();
                    end
                    else if (b == irc_lt_pkg::CH_CR)
                    begin
                        r.token_end = 1'b1;
                        bump_params();
                        ph = irc_lt_pkg::PH_TAIL;
                    end
                    else if (b == irc_lt_pkg::CH_COLON)
                    begin
                        r.token_kind = irc_lt_pkg::KIND_TRAIL;
                        ph = irc_lt_pkg::PH_TRAIL;
                    end
                    else
                    begin
                        r.token_kind = irc_lt_pkg::KIND_MIDDLE;
                        ph = irc_lt_pkg::PH_MID;
                    end
                end
                irc_lt_pkg::PH_MID:
                begin
                    if (b == irc_lt_pkg::CH_SP)
                    begin
                        r.token_end = 1'b1;
                        bump_params();
                        ph = irc_lt_pkg::PH_PSTART;
                    end
                    else if (b == irc_lt_pkg::CH_CR)
                    begin
                        r.token_end = 1'b1;
                        bump_params();
                        ph = irc_lt_pkg::PH_TAIL;
                    end
                    else
                        r.token_kind = irc_lt_pkg::KIND_MIDDLE;
                end
                irc_lt_pkg::PH_TRAIL:
                begin
                    if (b == irc_lt_pkg::CH_CR)
                    begin
                        r.token_end = 1'b1;
                        bump_params();
                        ph = irc_lt_pkg::PH_TAIL;
                    end
                    else
                        r.token_kind = irc_lt_pkg::KIND_TRAIL;
                end
                default:
                    ;
            endcase
            if (nbytes < irc_lt_pkg::COUNT_MAX)
                nbytes++;
        end
        tag_q.push_back(r);
    endfunction

    function void compare_tag(irc_lt_pkg::result_t got);
        irc_lt_pkg::result_t want;
        if (tag_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected item: byte=%h kind=%0d", got.byte_out, got.token_kind);
        end
        else
        begin
            want = tag_q.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display({"tag mismatch: exp byte=%h kind=%0d idx=%0d end=%b done=%b ",
                              "st=%0d cnt=%0d / got byte=%h kind=%0d idx=%0d end=%b done=%b ",
                              "st=%0d cnt=%0d"},
                             want.byte_out, want.token_kind, want.param_index,
                             want.token_end, want.line_done, want.status, want.param_total,
                             got.byte_out, got.token_kind, got.param_index,
                             got.token_end, got.line_done, got.status, got.param_total);
            end
        end
    endfunction
endclass

module irc_line_tokenizer_top_tb;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [9:0] cfg_wr_data = '0;
    logic       rx_valid = 1'b0;
    logic       rx_stall;
    logic [7:0] byte_in = '0;
    logic       tx_valid;
    logic       tx_stall = 1'b0;
    logic [7:0] byte_out;
    logic [2:0] token_kind;
    logic [3:0] param_index;
    logic       token_end;
    logic       line_done;
    logic [2:0] status;
    logic [3:0] param_total;

    irc_tag_tracker tags;
    logic [7:0] line_bytes[$];
    bit no_idle = 1'b0;
    bit hold_request = 1'b0;

    localparam int DIR_N = 32;
    logic [7:0] dir_bytes[DIR_N] = '{
        irc_lt_pkg::CH_LF,
        "P", "I", "N", "G", irc_lt_pkg::CH_SP, irc_lt_pkg::CH_LF,
        irc_lt_pkg::CH_COLON, irc_lt_pkg::CH_LF,
        irc_lt_pkg::CH_COLON, "a", irc_lt_pkg::CH_SP, "b", irc_lt_pkg::CH_LF,
        irc_lt_pkg::CH_COLON, "a", irc_lt_pkg::CH_SP, "b", irc_lt_pkg::CH_SP,
        irc_lt_pkg::CH_LF,
        irc_lt_pkg::CH_COLON, 8'h00, irc_lt_pkg::CH_SP, 8'hFF, irc_lt_pkg::CH_SP,
        irc_lt_pkg::CH_SP, irc_lt_pkg::CH_COLON, "t", irc_lt_pkg::CH_CR,
        irc_lt_pkg::CH_SP, "z", irc_lt_pkg::CH_LF
    };

    irc_line_tokenizer_top u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .byte_in     (byte_in),
        .tx_valid    (tx_valid),
        .tx_stall    (tx_stall),
        .byte_out    (byte_out),
        .token_kind  (token_kind),
        .param_index (param_index),
        .token_end   (token_end),
        .line_done   (line_done),
        .status      (status),
        .param_total (param_total)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] tok_byte(bit no_colon);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == irc_lt_pkg::CH_SP || b == irc_lt_pkg::CH_LF || b == irc_lt_pkg::CH_CR ||
               (no_colon && b == irc_lt_pkg::CH_COLON));
        return b;
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == irc_lt_pkg::CH_LF);
        return b;
    endfunction

    function automatic void make_line();
        int r;
        int n;
        int np;
        int cut;
        logic [7:0] b;
        logic [39:0] word;
        word = "PING ";
        line_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            line_bytes.push_back(irc_lt_pkg::CH_COLON);
            n = $urandom_range(0, 6);
            repeat (n)
                line_bytes.push_back(($urandom_range(0, 9) == 0) ?
                                     irc_lt_pkg::CH_CR : tok_byte(1'b0));
            line_bytes.push_back(irc_lt_pkg::CH_SP);
            repeat ($urandom_range(1, 5))
                line_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
            line_bytes.push_back(irc_lt_pkg::CH_SP);
            np = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 5);
            for (int i = 0; i < np; i++)
            begin
                if (i > 0)
                    line_bytes.push_back(irc_lt_pkg::CH_SP);
                n = $urandom_range(0, 4);
                for (int k = 0; k < n; k++)
                    line_bytes.push_back(tok_byte(k == 0));
            end
            if ($urandom_range(0, 1) == 1)
            begin
                if (np > 0)
                    line_bytes.push_back(irc_lt_pkg::CH_SP);
                line_bytes.push_back(irc_lt_pkg::CH_COLON);
                repeat ($urandom_range(0, 10))
                begin
                    b = any_but_lf();
                    line_bytes.push_back((b == irc_lt_pkg::CH_CR) ? irc_lt_pkg::CH_SP : b);
                end
            end
            r = $urandom_range(0, 9);
            if (r < 6)
                line_bytes.push_back(irc_lt_pkg::CH_CR);
            else if (r == 6)
            begin
                line_bytes.push_back(irc_lt_pkg::CH_CR);
                repeat ($urandom_range(1, 4))
                    line_bytes.push_back(any_but_lf());
            end
            // cut short: LF inside prefix, command, params or the bytes after CR
            if ($urandom_range(0, 19) == 0)
            begin
                cut = $urandom_range(1, line_bytes.size());
                while (line_bytes.size() > cut)
                    void'(line_bytes.pop_back());
            end
        end
        else if (r < 75)
        begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
                line_bytes.push_back(word[8 * (4 - i) +: 8]);
            if ($urandom_range(0, 2) == 0)
                line_bytes[$urandom_range(0, n - 1)] = any_but_lf();
            repeat ($urandom_range(0, 8))
                line_bytes.push_back(any_but_lf());
        end
        else if (r < 85)
        begin
            do
                b = any_but_lf();
            while (b == irc_lt_pkg::CH_COLON);
            line_bytes.push_back(b);
            repeat ($urandom_range(0, 10))
                line_bytes.push_back(any_but_lf());
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        line_bytes.push_back(irc_lt_pkg::CH_LF);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        byte_in <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        tags.accept_byte(b);
    endtask

    task automatic send_line(inout int sent);
        foreach (line_bytes[i])
            send_byte(line_bytes[i]);
        sent += line_bytes.size();
    endtask

    task automatic wait_idle();
        rx_valid <= 1'b0;
        while (tags.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [9:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tags.limit_reg = v;
    endtask

    // result side: check, then pick next stall
    initial
    begin
        int run_left;
        int hold_left;
        run_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && tx_valid && !tx_stall)
                tags.compare_tag({byte_out, token_kind, param_index, token_end,
                                  line_done, status, param_total});
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 250;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                tx_stall <= 1'b1;
            end
            else if (run_left > 0)
            begin
                run_left--;
                tx_stall <= 1'b1;
            end
            else
            begin
                run_left = pick_gap();
                tx_stall <= (run_left > 0);
                if (run_left > 0)
                    run_left--;
            end
        end
    end

    initial
    begin
        #5ms;
        $display("irc_line_tokenizer_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        int limits[6];
        int sent;
        bit paused;
        logic [9:0] lim;
        tags = new();
        limits = '{2, 512, 24, 0, 3, 0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_byte(dir_bytes[i]);

        for (int p = 0; p < 6; p++)
        begin
            wait_idle();
            if (p == 3)
                lim = 10'($urandom_range(2, 512));
            else if (p == 5)
                lim = 10'($urandom_range(4, 60));
            else
                lim = 10'(limits[p]);
            write_limit(lim);
            no_idle = (p == 2);
            sent = 0;
            paused = 1'b0;
            if (p == 1)
                hold_request = 1'b1;
            while (sent < 30)
            begin
                make_line();
                send_line(sent);
                if (p == 1 && !paused && sent > 15)
                begin
                    paused = 1'b1;
                    wait_idle();
                end
            end
            // line length overflow: a trailing parameter longer than the line limit of 512
            if (p == 1)
            begin
                line_bytes.delete();
                line_bytes = '{irc_lt_pkg::CH_COLON, "a", irc_lt_pkg::CH_SP, "C", "M", "D",
                               irc_lt_pkg::CH_SP, irc_lt_pkg::CH_COLON};
                repeat (520)
                    line_bytes.push_back(8'($urandom_range(8'h41, 8'h7A)));
                line_bytes.push_back(irc_lt_pkg::CH_CR);
                line_bytes.push_back(irc_lt_pkg::CH_LF);
                send_line(sent);
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (tags.errors == 0)
            $display("irc_line_tokenizer_top_tb: done, clean");
        else
            $display("irc_line_tokenizer_top_tb: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/irc_lt_pkg.sv
hw/rtl/irc_lt_core.sv
hw/rtl/irc_line_tokenizer_top.sv
verif/irc_line_tokenizer_top_tb.sv
